### hw/rtl/lfia_pkg.sv
// ----------------------------------------------------------------------------
// lfia_pkg
// Shared constants and helpers for the lowest-free id allocator.
// ----------------------------------------------------------------------------
package lfia_pkg;

	localparam int SLOT_COUNT_DEF = 512;
	localparam int WORD_W         = 32;
	localparam int WBIT_W         = 5;
	localparam int ID_W           = 9;
	localparam int COUNT_W        = 10;
	localparam int IN_DATA_W      = 16;
	localparam int OUT_DATA_W     = 32;

	localparam logic CMD_OBTAIN  = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	// {found, index of the lowest set bit}
	function automatic logic [WBIT_W:0] lowest_one(input logic [WORD_W-1:0] vec);
		logic [WBIT_W:0] res;
		res = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (vec[i]) begin
				res = {1'b1, WBIT_W'(i)};
			end
		end
		return res;
	endfunction

endpackage

### hw/rtl/lowest_free_id_allocator_with_leader_core.sv
// ----------------------------------------------------------------------------
// lowest_free_id_allocator_with_leader_core
// Slot allocator: grants the lowest free slot, frees slots, tracks the leader.
// ----------------------------------------------------------------------------
// The busy map lives in a single-port memory of 32-bit words, one bit per slot,
// with a full flag and a non-empty flag per word kept in flip-flops. Rows never
// written read as all free, so the block is ready right after reset with no
// clearing pass. One item is handled at a time. An obtain walks the per-word
// full flags in chunks of 32 words to find a word with a free bit, reads that
// word and writes it back with its lowest free bit set. A release reads the
// slot's word and clears the bit if set; when it frees the leader, the
// non-empty flags are walked the same way and the lowest busy word is read
// for the new leader. A full pool or an out-of-range release goes straight
// to the output state. The result is loaded only once the output register is
// empty or being taken, and a new item is accepted from the cycle after that
// load, even while the result still waits to be taken.
module lowest_free_id_allocator_with_leader_core #(
	parameter int SLOT_COUNT = lfia_pkg::SLOT_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [8:0] slot_id, [15:9] zero
	input  logic [lfia_pkg::IN_DATA_W-1:0]  s_tdata,
	// [0] command
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [8:0] granted_id, [9] grant_ok, [10] release_ignored, [19:11] leader_id,
	// [20] leader_valid, [30:21] busy_count, [31] zero
	output logic [lfia_pkg::OUT_DATA_W-1:0] m_tdata
);
	import lfia_pkg::*;

	localparam int NW   = (SLOT_COUNT + WORD_W - 1) / WORD_W;
	localparam int NCH  = (NW + WORD_W - 1) / WORD_W;
	localparam int WAW  = (NW > 1) ? $clog2(NW) : 1;
	localparam int CIW  = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int IDW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNTW = $clog2(SLOT_COUNT + 1);
	localparam int REM  = SLOT_COUNT % WORD_W;
	localparam logic [WORD_W-1:0] LAST_PAD =
		(REM == 0) ? '0 : ~((WORD_W'(1) << REM) - WORD_W'(1));

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_SCAN = 8'b0000_0010,
		S_RD   = 8'b0000_0100,
		S_MOD  = 8'b0000_1000,
		S_LSCN = 8'b0001_0000,
		S_LRD  = 8'b0010_0000,
		S_LMOD = 8'b0100_0000,
		S_OUT  = 8'b1000_0000
	} state_t;

	state_t              state_q;
	logic                cmd_q;
	logic [IDW-1:0]      sid_q;
	logic [CIW-1:0]      ch_q;
	logic [WAW-1:0]      addr_q;
	logic [WORD_W-1:0]   rdata_q;
	logic [NW-1:0]       row_valid_q;
	logic [NW-1:0]       full_q;
	logic [NW-1:0]       nonempty_q;
	logic [CNTW-1:0]     count_q;
	logic [IDW-1:0]      leader_q;
	logic                leader_vld_q;
	logic [IDW-1:0]      granted_q;
	logic                ok_q;
	logic                ign_q;
	logic                m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic [WORD_W-1:0]   mem [NW];

	logic [NCH*WORD_W-1:0] full_pad;
	logic [NCH*WORD_W-1:0] ne_pad;
	logic [WORD_W-1:0]   full_chunk;
	logic [WORD_W-1:0]   ne_chunk;
	logic [WBIT_W:0]     free_word_hit;
	logic [WBIT_W:0]     busy_word_hit;
	logic [WAW-1:0]      free_word_addr;
	logic [WAW-1:0]      busy_word_addr;
	logic [WORD_W-1:0]   word_eff;
	logic [WORD_W-1:0]   pad_mask;
	logic [WBIT_W:0]     free_bit_hit;
	logic [WBIT_W:0]     busy_bit_hit;
	logic [WBIT_W-1:0]   rel_bit;
	logic [WORD_W-1:0]   rel_onehot;
	logic [WORD_W-1:0]   obt_onehot;
	logic [WORD_W-1:0]   obt_word;
	logic [WORD_W-1:0]   rel_word;
	logic [IDW-1:0]      obt_slot;
	logic [IDW-1:0]      lead_slot;
	logic [CNTW-1:0]     count_dec;
	logic                accept;
	logic                rel_hit;
	logic                out_load;
	logic                in_range;
	logic                mem_we;
	logic [WORD_W-1:0]   mem_wdata;

	// Pad the per-word flags to whole chunks: missing words look full and empty
	for (genvar i = 0; i < NCH * WORD_W; i++) begin : g_pad
		if (i < NW) begin : g_real
			assign full_pad[i] = full_q[i];
			assign ne_pad[i]   = nonempty_q[i];
		end else begin : g_fill
			assign full_pad[i] = 1'b1;
			assign ne_pad[i]   = 1'b0;
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign in_range = (32'(s_tdata[ID_W-1:0]) < 32'(SLOT_COUNT));
	assign out_load = (state_q == S_OUT) && (!m_tvalid_q || m_tready);

	always_comb begin
		full_chunk     = full_pad[ch_q*WORD_W +: WORD_W];
		ne_chunk       = ne_pad[ch_q*WORD_W +: WORD_W];
		free_word_hit  = lowest_one(~full_chunk);
		busy_word_hit  = lowest_one(ne_chunk);
		free_word_addr = WAW'({ch_q, free_word_hit[WBIT_W-1:0]});
		busy_word_addr = WAW'({ch_q, busy_word_hit[WBIT_W-1:0]});

		word_eff   = row_valid_q[addr_q] ? rdata_q : '0;
		pad_mask   = (addr_q == WAW'(NW - 1)) ? LAST_PAD : '0;
		free_bit_hit = lowest_one(~(word_eff | pad_mask));
		busy_bit_hit = lowest_one(word_eff);
		obt_onehot = WORD_W'(1) << free_bit_hit[WBIT_W-1:0];
		obt_word   = word_eff | obt_onehot;
		obt_slot   = IDW'({addr_q, free_bit_hit[WBIT_W-1:0]});
		lead_slot  = IDW'({addr_q, busy_bit_hit[WBIT_W-1:0]});

		rel_bit    = WBIT_W'(sid_q);
		rel_onehot = WORD_W'(1) << rel_bit;
		rel_word   = word_eff & ~rel_onehot;
		rel_hit    = word_eff[rel_bit];
		count_dec  = count_q - CNTW'(1);

		mem_we    = (state_q == S_MOD) && ((cmd_q == CMD_OBTAIN) || rel_hit);
		mem_wdata = (cmd_q == CMD_OBTAIN) ? obt_word : rel_word;
	end

	// Busy map storage: one read or one write a cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr_q] <= mem_wdata;
		end
		if (state_q == S_RD || state_q == S_LRD) begin
			rdata_q <= mem[addr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= s_tuser;
			sid_q <= IDW'(s_tdata[ID_W-1:0]);
		end
		if (out_load) begin
			m_tdata_q <= {1'b0, COUNT_W'(count_q), leader_vld_q, ID_W'(leader_q),
				ign_q, ok_q, ID_W'(granted_q)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ch_q         <= '0;
			addr_q       <= '0;
			row_valid_q  <= '0;
			full_q       <= '0;
			nonempty_q   <= '0;
			count_q      <= '0;
			leader_q     <= '0;
			leader_vld_q <= 1'b0;
			granted_q    <= '0;
			ok_q         <= 1'b0;
			ign_q        <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						granted_q <= '0;
						ok_q      <= 1'b0;
						ign_q     <= 1'b0;
						ch_q      <= '0;
						if (s_tuser == CMD_OBTAIN) begin
							// pool full: answer at once
							state_q <= (count_q == CNTW'(SLOT_COUNT)) ? S_OUT : S_SCAN;
						end else if (in_range) begin
							addr_q  <= WAW'(IDW'(s_tdata[ID_W-1:0]) >> WBIT_W);
							state_q <= S_RD;
						end else begin
							ign_q   <= 1'b1;
							state_q <= S_OUT;
						end
					end
				end
				S_SCAN: begin
					if (free_word_hit[WBIT_W]) begin
						addr_q  <= free_word_addr;
						state_q <= S_RD;
					end else begin
						ch_q <= ch_q + CIW'(1);
					end
				end
				S_RD: begin
					state_q <= S_MOD;
				end
				S_MOD: begin
					if (cmd_q == CMD_OBTAIN) begin
						row_valid_q[addr_q] <= 1'b1;
						full_q[addr_q]      <= &(obt_word | pad_mask);
						nonempty_q[addr_q]  <= 1'b1;
						count_q             <= count_q + CNTW'(1);
						granted_q           <= obt_slot;
						ok_q                <= 1'b1;
						if (!leader_vld_q || obt_slot < leader_q) begin
							leader_q     <= obt_slot;
							leader_vld_q <= 1'b1;
						end
						state_q <= S_OUT;
					end else if (!rel_hit) begin
						ign_q   <= 1'b1;
						state_q <= S_OUT;
					end else begin
						row_valid_q[addr_q] <= 1'b1;
						full_q[addr_q]      <= 1'b0;
						nonempty_q[addr_q]  <= |rel_word;
						count_q             <= count_dec;
						if (count_dec == '0) begin
							leader_q     <= '0;
							leader_vld_q <= 1'b0;
							state_q      <= S_OUT;
						end else if (sid_q == leader_q) begin
							// leader freed: find the lowest busy word again
							ch_q    <= '0;
							state_q <= S_LSCN;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_LSCN: begin
					if (busy_word_hit[WBIT_W]) begin
						addr_q  <= busy_word_addr;
						state_q <= S_LRD;
					end else begin
						ch_q <= ch_q + CIW'(1);
					end
				end
				S_LRD: begin
					state_q <= S_LMOD;
				end
				S_LMOD: begin
					leader_q <= lead_slot;
					state_q  <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(SLOT_COUNT))
		else $error("busy count above pool size");

	a_leader_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		leader_vld_q == (count_q != '0))
		else $error("leader valid disagrees with busy count");

	a_scan_has_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !(&full_q))
		else $error("free search started on a full pool");

	a_lscan_has_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LSCN) |-> (|nonempty_q))
		else $error("leader search with no busy word");

	a_lmod_word_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LMOD) |-> busy_bit_hit[WBIT_W])
		else $error("leader word read back empty");
`endif

endmodule

### verif/lfia_alloc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfia_alloc_checker
// Watches both item channels of the slot allocator, keeps its own copy of the
// busy map, count and leader, and compares each result with the prediction.
// ----------------------------------------------------------------------------
module lfia_alloc_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	// [8:0] slot_id, [15:9] zero
	input  logic [lfia_pkg::IN_DATA_W-1:0]  s_tdata,
	// [0] command
	input  logic                            s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	// [8:0] granted_id, [9] grant_ok, [10] release_ignored, [19:11] leader_id,
	// [20] leader_valid, [30:21] busy_count, [31] zero
	input  logic [lfia_pkg::OUT_DATA_W-1:0] m_tdata,
	output int                              fail_count,
	output int                              pending,
	output int                              checked,
	output int                              full_refusals,
	output int                              ignored_releases,
	output int                              leader_moves
);
	import lfia_pkg::*;

	localparam int SLOTS = SLOT_COUNT_DEF;

	typedef struct packed {
		logic               pad;
		logic [COUNT_W-1:0] busy_count;
		logic               leader_valid;
		logic [ID_W-1:0]    leader_id;
		logic               release_ignored;
		logic               grant_ok;
		logic [ID_W-1:0]    granted_id;
	} alloc_result_t;

	logic [SLOTS-1:0]   busy_map   = '0;
	logic [COUNT_W-1:0] busy_total = '0;
	logic [ID_W-1:0]    leader     = '0;
	logic               leader_on  = 1'b0;
	alloc_result_t      expected_results[$];

	function automatic int lowest_set(input logic [SLOTS-1:0] map);
		int idx;
		idx = -1;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (map[i]) begin
				idx = i;
			end
		end
		return idx;
	endfunction

	// Update the pool for one request and return the result it must produce.
	function automatic alloc_result_t apply_request(input logic cmd,
			input logic [ID_W-1:0] sid);
		alloc_result_t r;
		int            slot;
		r = '0;
		if (cmd == CMD_OBTAIN) begin
			slot = lowest_set(~busy_map);
			if (slot >= 0) begin
				busy_map[ID_W'(slot)] = 1'b1;
				busy_total            = busy_total + COUNT_W'(1);
				if (!leader_on || slot < int'(leader)) begin
					leader    = ID_W'(slot);
					leader_on = 1'b1;
				end
				r.granted_id = ID_W'(slot);
				r.grant_ok   = 1'b1;
			end else begin
				full_refusals++;
			end
		end else if (int'(sid) < SLOTS && busy_map[sid]) begin
			busy_map[sid] = 1'b0;
			busy_total    = busy_total - COUNT_W'(1);
			if (busy_total == '0) begin
				leader_on = 1'b0;
				leader    = '0;
			end else if (sid == leader) begin
				// hand the lead to the lowest slot still busy
				leader = ID_W'(lowest_set(busy_map));
				leader_moves++;
			end
		end else begin
			r.release_ignored = 1'b1;
			ignored_releases++;
		end
		r.leader_id    = leader_on ? leader : '0;
		r.leader_valid = leader_on;
		r.busy_count   = busy_total;
		return r;
	endfunction

	function automatic void compare_field(input string name, input int want_v,
			input int got_v);
		if (want_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		alloc_result_t want;
		alloc_result_t got;
		if (!arst_n) begin
			busy_map   = '0;
			busy_total = '0;
			leader     = '0;
			leader_on  = 1'b0;
			expected_results.delete();
			pending <= 0;
		end else begin
			// retire the result first: it belongs to an earlier item
			if (m_tvalid && m_tready) begin
				got = alloc_result_t'(m_tdata);
				if (expected_results.size() == 0) begin
					$error("unexpected result item: m_tdata 0x%08h", m_tdata);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					compare_field("granted_id", int'(want.granted_id),
						int'(got.granted_id));
					compare_field("grant_ok", int'(want.grant_ok), int'(got.grant_ok));
					compare_field("release_ignored", int'(want.release_ignored),
						int'(got.release_ignored));
					compare_field("leader_id", int'(want.leader_id), int'(got.leader_id));
					compare_field("leader_valid", int'(want.leader_valid),
						int'(got.leader_valid));
					compare_field("busy_count", int'(want.busy_count),
						int'(got.busy_count));
					compare_field("pad", int'(want.pad), int'(got.pad));
					checked++;
				end
			end
			if (s_tvalid && s_tready) begin
				expected_results.push_back(apply_request(s_tuser, s_tdata[ID_W-1:0]));
			end
			pending <= expected_results.size();
		end
	end

endmodule

### verif/tb_lowest_free_id_allocator_with_leader_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lowest_free_id_allocator_with_leader_core
// Drives obtain and release items into the slot allocator: a directed opening,
// then random mixes, a fill to a full pool and a drain back to empty, with random
// gaps on both channels but in the first mix; the checker beside it scores.
// ----------------------------------------------------------------------------
module tb_lowest_free_id_allocator_with_leader_core;
	import lfia_pkg::*;

	localparam int SLOTS          = SLOT_COUNT_DEF;
	localparam int RX_HOLD_CYCLES = 400;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic                  s_tuser  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	logic                  calm     = 1'b0;
	logic                  hold_req = 1'b0;
	logic [SLOTS-1:0]      held_map = '0;
	int                    held_count = 0;
	int                    sent       = 0;

	int fail_count;
	int pending;
	int checked;
	int full_refusals;
	int ignored_releases;
	int leader_moves;

	always #5 clk = ~clk;

	lowest_free_id_allocator_with_leader_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	lfia_alloc_checker u_alloc_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.s_tuser          (s_tuser),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.fail_count       (fail_count),
		.pending          (pending),
		.checked          (checked),
		.full_refusals    (full_refusals),
		.ignored_releases (ignored_releases),
		.leader_moves     (leader_moves)
	);

	initial begin : timeout_guard
		#5ms;
		$display("Simulation FAILED");
		$finish;
	end

	// result side: random stalls, or one long hold-off on request
	initial begin : sink
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			m_tready <= calm || ($urandom_range(0, 99) >= 37);
			@(posedge clk);
		end
	end

	function automatic int first_set(input logic [SLOTS-1:0] map);
		int idx;
		idx = -1;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (map[i]) begin
				idx = i;
			end
		end
		return idx;
	endfunction

	function automatic logic [ID_W-1:0] pick_busy();
		int start;
		start = $urandom_range(0, SLOTS - 1);
		for (int k = 0; k < SLOTS; k++) begin
			if (held_map[(start + k) % SLOTS]) begin
				return ID_W'((start + k) % SLOTS);
			end
		end
		return ID_W'(start);
	endfunction

	task automatic send_item(input logic cmd, input logic [ID_W-1:0] sid);
		int slot;
		while (!calm && $urandom_range(0, 99) < 37) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= IN_DATA_W'(sid);
		do @(posedge clk); while (!s_tready);
		// shadow of the pool, only to steer which slots get released
		if (cmd == CMD_OBTAIN) begin
			slot = first_set(~held_map);
			if (slot >= 0) begin
				held_map[slot] = 1'b1;
				held_count++;
			end
		end else if (held_map[sid]) begin
			held_map[sid] = 1'b0;
			held_count--;
		end
		sent++;
	endtask

	task automatic send_random_release();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			send_item(CMD_RELEASE, ID_W'(first_set(held_map)));
		end else if (pick < 25) begin
			send_item(CMD_RELEASE, ID_W'($urandom));
		end else begin
			send_item(CMD_RELEASE, pick_busy());
		end
	endtask

	task automatic run_mix(input int count, input int obtain_pct);
		repeat (count) begin
			if ($urandom_range(0, 99) < obtain_pct) begin
				send_item(CMD_OBTAIN, ID_W'($urandom));
			end else begin
				send_random_release();
			end
		end
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin : stimulus
		int extra;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(CMD_OBTAIN, '0);
		send_item(CMD_OBTAIN, '1);
		send_item(CMD_OBTAIN, 9'h155);
		send_item(CMD_RELEASE, 9'd1);
		send_item(CMD_RELEASE, 9'd1);
		send_item(CMD_RELEASE, 9'd0);
		send_item(CMD_RELEASE, 9'd511);
		send_item(CMD_OBTAIN, 9'h0aa);
		send_item(CMD_OBTAIN, '0);
		send_item(CMD_RELEASE, 9'd2);
		send_item(CMD_RELEASE, 9'd0);
		send_item(CMD_RELEASE, 9'd1);
		send_item(CMD_RELEASE, 9'd0);
		send_item(CMD_RELEASE, 9'h100);
		send_item(CMD_OBTAIN, 9'h1ff);
		send_item(CMD_RELEASE, 9'h0ff);
		send_item(CMD_RELEASE, 9'd0);
		wait_idle();

		calm = 1'b1;
		run_mix(150, 60);
		calm = 1'b0;
		run_mix(300, 55);

		// fill to a full pool while the result side holds off
		hold_req = 1'b1;
		extra = SLOTS - held_count + 4;
		repeat (extra) send_item(CMD_OBTAIN, ID_W'($urandom));
		repeat (12) begin
			send_item(CMD_RELEASE, pick_busy());
			send_item(CMD_OBTAIN, ID_W'($urandom));
		end
		send_item(CMD_RELEASE, ID_W'(first_set(held_map)));
		send_item(CMD_OBTAIN, '0);
		send_item(CMD_OBTAIN, '1);
		wait_idle();

		run_mix(250, 20);
		while (held_count > 0) begin
			send_item(CMD_RELEASE, pick_busy());
		end
		send_item(CMD_RELEASE, ID_W'($urandom));
		wait_idle();
		repeat (20) @(posedge clk);

		$display("Sent %0d items, checked %0d results: %0d refused on a full pool,",
			sent, checked, full_refusals);
		$display("%0d releases of free slots, %0d leader hand-overs.",
			ignored_releases, leader_moves);
		if (fail_count == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

### files.f
hw/rtl/lfia_pkg.sv
hw/rtl/lowest_free_id_allocator_with_leader_core.sv
verif/lfia_alloc_checker.sv
verif/tb_lowest_free_id_allocator_with_leader_core.sv
